>>> rtl/core/bsl_pkg.sv
// Shared types and constants of the bounded sorted list.
package bsl_pkg;

    localparam int LIST_DEPTH    = 16;
    localparam int VALUE_W       = 32;
    localparam int OP_W          = 2;
    localparam int ENTRY_COUNT_W = 5;
    localparam int CNT_W         = $clog2(LIST_DEPTH + 1);

    typedef enum logic [OP_W-1:0] {
        OP_SORTED = 2'd0,
        OP_FRONT  = 2'd1,
        OP_BACK   = 2'd2,
        OP_READ   = 2'd3
    } t_op;

    // Broadcast from the controller to every cell of the row
    typedef struct packed {
        logic                ins_en;
        logic                rot_en;
        t_op                 op;
        logic [VALUE_W-1:0]  value;
        logic [CNT_W-1:0]    count;
    } t_bsl_ctl;

endpackage

>>> rtl/core/bsl_if.sv
// Valid/ready channel interfaces for input items and result items.
interface bsl_in_if import bsl_pkg::*; ();
    logic                valid;
    logic                ready;
    logic [OP_W-1:0]     op;
    logic [VALUE_W-1:0]  value;

    modport source (output valid, output op, output value, input ready);
    modport sink   (input valid, input op, input value, output ready);
endinterface

interface bsl_out_if import bsl_pkg::*; ();
    logic                      valid;
    logic                      ready;
    logic                      has_value;
    logic [VALUE_W-1:0]        element;
    logic [ENTRY_COUNT_W-1:0]  entry_count;
    logic                      dropped;
    logic                      last;

    modport source (output valid, output has_value, output element, output entry_count,
                    output dropped, output last, input ready);
    modport sink   (input valid, input has_value, input element, input entry_count,
                    input dropped, input last, output ready);
endinterface

>>> rtl/core/bounded_sorted_list_insert_top.sv
// Top level of the bounded sorted list: controller, output register and cell row.
//
// Usage: items arrive on i_in (op, value) and results leave on o_out, both
// valid/ready; a beat moves when valid and ready are high at a clock edge.
// An insert (sorted, front or back) is decided by all cells comparing the
// value in parallel: its single result beat, carrying the new count, is in
// the output register on the next cycle. An insert into a full list leaves
// the list alone and returns a beat with dropped set.
// A read-out emits one beat per stored entry from the head cell while the row
// rotates; the row is back in its original order after the last beat. A read
// of an empty list returns one beat with has_value clear.
// Throughput: one insert per cycle while o_out is taken every cycle; a
// read-out blocks i_in until its last beat enters the output register.
// A stalled receiver holds the output register; the row pauses its rotation
// and i_in holds ready low until the pending beat is taken.
// Reset (i_rst_n low at a clock edge) empties the list and drops any pending
// beat; entry storage itself is not cleared.
module bounded_sorted_list_insert_top import bsl_pkg::*; (
    input  logic       i_clk,
    input  logic       i_rst_n,
    bsl_in_if.sink     i_in,
    bsl_out_if.source  o_out
);

    typedef enum logic [1:0] {
        ST_IDLE = 2'b01,
        ST_READ = 2'b10
    } t_state;

    t_state                    r_state, n_state;
    logic [CNT_W-1:0]          r_count, n_count;
    logic [CNT_W-1:0]          r_rd_idx, n_rd_idx;
    logic                      r_out_valid, n_out_valid;
    logic                      r_has_value, n_has_value;
    logic [VALUE_W-1:0]        r_element, n_element;
    logic [ENTRY_COUNT_W-1:0]  r_entry_count, n_entry_count;
    logic                      r_dropped, n_dropped;
    logic                      r_last, n_last;

    t_bsl_ctl                  ctl;
    t_op                       op;
    logic                      out_free;
    logic                      acc;
    logic                      full;
    logic                      rd_last;
    logic [VALUE_W-1:0]        head_entry;

    assign op       = t_op'(i_in.op);
    assign out_free = !r_out_valid || o_out.ready;
    assign i_in.ready = (r_state == ST_IDLE) && out_free;
    assign acc      = i_in.valid && i_in.ready;
    assign full     = r_count == CNT_W'(LIST_DEPTH);
    assign rd_last  = (r_rd_idx + CNT_W'(1)) == r_count;

    // Drive the cell row
    always_comb begin
        ctl.ins_en = acc && (op != OP_READ) && !full;
        ctl.rot_en = (r_state == ST_READ) && out_free;
        ctl.op     = op;
        ctl.value  = i_in.value;
        ctl.count  = r_count;
    end

    bsl_row u_row (
        .i_clk        (i_clk),
        .i_ctl        (ctl),
        .o_head_entry (head_entry)
    );

    // Sequence items and fill the output register
    always_comb begin
        n_state       = r_state;
        n_count       = r_count;
        n_rd_idx      = r_rd_idx;
        n_out_valid   = r_out_valid && !o_out.ready;
        n_has_value   = r_has_value;
        n_element     = r_element;
        n_entry_count = r_entry_count;
        n_dropped     = r_dropped;
        n_last        = r_last;
        case (r_state)
            ST_IDLE: begin
                if (acc) begin
                    if (op == OP_READ && r_count != '0) begin
                        n_state  = ST_READ;
                        n_rd_idx = '0;
                    end else begin
                        n_out_valid   = 1'b1;
                        n_has_value   = 1'b0;
                        n_element     = '0;
                        n_dropped     = (op != OP_READ) && full;
                        n_last        = 1'b1;
                        n_entry_count = ENTRY_COUNT_W'(r_count);
                        if (ctl.ins_en) begin
                            n_count       = r_count + CNT_W'(1);
                            n_entry_count = ENTRY_COUNT_W'(r_count + CNT_W'(1));
                        end
                    end
                end
            end
            ST_READ: begin
                if (ctl.rot_en) begin
                    n_out_valid   = 1'b1;
                    n_has_value   = 1'b1;
                    n_element     = head_entry;
                    n_entry_count = ENTRY_COUNT_W'(r_count);
                    n_dropped     = 1'b0;
                    n_last        = rd_last;
                    n_rd_idx      = r_rd_idx + CNT_W'(1);
                    if (rd_last) begin
                        n_state = ST_IDLE;
                    end
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    // Control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_count     <= '0;
            r_rd_idx    <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_count     <= n_count;
            r_rd_idx    <= n_rd_idx;
            r_out_valid <= n_out_valid;
        end
    end

    // Output payload registers
    always_ff @(posedge i_clk) begin
        r_has_value   <= n_has_value;
        r_element     <= n_element;
        r_entry_count <= n_entry_count;
        r_dropped     <= n_dropped;
        r_last        <= n_last;
    end

    assign o_out.valid       = r_out_valid;
    assign o_out.has_value   = r_has_value;
    assign o_out.element     = r_element;
    assign o_out.entry_count = r_entry_count;
    assign o_out.dropped     = r_dropped;
    assign o_out.last        = r_last;

endmodule

>>> rtl/core/bsl_cell.sv
// One list cell: holds an entry, decides insertion locally, shifts or rotates.
module bsl_cell import bsl_pkg::*; (
    input  logic                i_clk,
    input  t_bsl_ctl            i_ctl,
    input  logic [CNT_W-1:0]    i_index,
    input  logic [VALUE_W-1:0]  i_prev_entry,
    input  logic                i_prev_mark,
    input  logic [VALUE_W-1:0]  i_next_entry,
    input  logic [VALUE_W-1:0]  i_head_entry,
    output logic [VALUE_W-1:0]  o_entry,
    output logic                o_mark
);

    logic [VALUE_W-1:0] r_entry;
    logic [VALUE_W-1:0] n_entry;
    logic               occ;
    logic               last_occ;
    logic               at_end;
    logic               cond;
    logic               hit;

    // Locate this cell against the fill level
    assign occ      = i_index < i_ctl.count;
    assign at_end   = i_index == i_ctl.count;
    assign last_occ = (i_index + CNT_W'(1)) == i_ctl.count;

    // Head cell stops on a greater entry, later cells on one not less
    always_comb begin
        if (i_index == '0) begin
            cond = $signed(i_ctl.value) < $signed(r_entry);
        end else begin
            cond = !($signed(r_entry) < $signed(i_ctl.value));
        end
    end

    // Decide whether the insertion point is this cell
    always_comb begin
        case (i_ctl.op)
            OP_SORTED: hit = (occ & cond) | at_end;
            OP_FRONT:  hit = 1'b1;
            OP_BACK:   hit = at_end;
            default:   hit = 1'b0;
        endcase
    end

    assign o_mark = i_prev_mark | hit;

    // Load value, shift from left, rotate from right, or hold
    always_comb begin
        n_entry = r_entry;
        if (i_ctl.ins_en) begin
            if (i_prev_mark) begin
                n_entry = i_prev_entry;
            end else if (hit) begin
                n_entry = i_ctl.value;
            end
        end else if (i_ctl.rot_en && occ) begin
            n_entry = last_occ ? i_head_entry : i_next_entry;
        end
    end

    always_ff @(posedge i_clk) begin
        r_entry <= n_entry;
    end

    assign o_entry = r_entry;

endmodule

>>> rtl/core/bsl_row.sv
// Row of list cells chained by entry and insertion-mark links.
module bsl_row import bsl_pkg::*; (
    input  logic                i_clk,
    input  t_bsl_ctl            i_ctl,
    output logic [VALUE_W-1:0]  o_head_entry
);

    logic [VALUE_W-1:0] entry [LIST_DEPTH];
    logic               mark  [LIST_DEPTH];

    genvar g;
    generate
        for (g = 0; g < LIST_DEPTH; g++) begin : g_cell
            logic [VALUE_W-1:0] prev_entry;
            logic               prev_mark;
            logic [VALUE_W-1:0] next_entry;

            // Tie off the row ends
            if (g == 0) begin : g_first
                assign prev_entry = i_ctl.value;
                assign prev_mark  = 1'b0;
            end else begin : g_mid
                assign prev_entry = entry[g-1];
                assign prev_mark  = mark[g-1];
            end
            if (g == LIST_DEPTH - 1) begin : g_last
                assign next_entry = entry[0];
            end else begin : g_body
                assign next_entry = entry[g+1];
            end

            bsl_cell u_cell (
                .i_clk        (i_clk),
                .i_ctl        (i_ctl),
                .i_index      (CNT_W'(g)),
                .i_prev_entry (prev_entry),
                .i_prev_mark  (prev_mark),
                .i_next_entry (next_entry),
                .i_head_entry (entry[0]),
                .o_entry      (entry[g]),
                .o_mark       (mark[g])
            );
        end
    endgenerate

    assign o_head_entry = entry[0];

endmodule

>>> bench/testbench.sv
// Self-checking testbench of the bounded sorted list: shadow list, stimulus tasks, result check.
`timescale 1ns / 100ps

module testbench;
    import bsl_pkg::*;

    localparam int RESET_CYCLES = 6;
    localparam int CYCLE_LIMIT  = 400000;
    localparam int DRAIN_LIMIT  = 20000;
    localparam int SETTLE_GAP   = LIST_DEPTH + 8;
    localparam int HOLD_CYCLES  = 300;
    localparam int PHASE_ITEMS  = 100;
    localparam int MAX_REPORTS  = 10;

    localparam logic [VALUE_W-1:0] MOST_NEGATIVE = 32'h8000_0000;
    localparam logic [VALUE_W-1:0] MOST_POSITIVE = 32'h7fff_ffff;

    typedef struct {
        logic                      has_value;
        logic [VALUE_W-1:0]        element;
        logic [ENTRY_COUNT_W-1:0]  entry_count;
        logic                      dropped;
        logic                      last;
    } t_list_beat;

    logic i_clk = 1'b0;
    logic i_rst_n;

    bsl_in_if  in_ch ();
    bsl_out_if out_ch ();

    bounded_sorted_list_insert_top dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (in_ch),
        .o_out   (out_ch)
    );

    // Shadow copy of the list contents and fill level
    logic [VALUE_W-1:0] shadow_entries [LIST_DEPTH];
    int                 shadow_count;

    t_list_beat pending_beats [$];

    int fail_count;
    int cycle_count;
    int sender_idle_pct;
    int receiver_stall_pct;
    int hold_requests;

    // 4 ns clock
    always begin
        #2 i_clk = 1'b1;
        #2 i_clk = 1'b0;
    end

    // Log one failure; only the first few are printed
    function automatic void note_failure(string msg);
        if (fail_count < MAX_REPORTS) begin
            $display("[%0t] %s", $realtime, msg);
        end
        fail_count++;
    endfunction

    function automatic void push_beat(logic hv, logic [VALUE_W-1:0] elem, int cnt,
                                      logic drop, logic fin);
        t_list_beat b;
        b.has_value   = hv;
        b.element     = elem;
        b.entry_count = cnt[ENTRY_COUNT_W-1:0];
        b.dropped     = drop;
        b.last        = fin;
        pending_beats.push_back(b);
    endfunction

    // Apply one accepted item to the shadow list and queue the beats it yields
    function automatic void apply_list_item(t_op op, logic [VALUE_W-1:0] v);
        int pos;
        if (op == OP_READ) begin
            if (shadow_count == 0) begin
                push_beat(1'b0, '0, 0, 1'b0, 1'b1);
            end else begin
                for (int k = 0; k < shadow_count; k++) begin
                    push_beat(1'b1, shadow_entries[k], shadow_count, 1'b0,
                              k == shadow_count - 1);
                end
            end
        end else if (shadow_count >= LIST_DEPTH) begin
            // full list: refuse the insert
            push_beat(1'b0, '0, LIST_DEPTH, 1'b1, 1'b1);
        end else begin
            case (op)
                OP_FRONT: begin
                    pos = 0;
                end
                OP_BACK: begin
                    pos = shadow_count;
                end
                default: begin
                    // go first, or start after the head and skip entries less than v
                    if (shadow_count == 0 || $signed(v) < $signed(shadow_entries[0])) begin
                        pos = 0;
                    end else begin
                        pos = 1;
                        while (pos < shadow_count &&
                               $signed(shadow_entries[pos]) < $signed(v)) begin
                            pos++;
                        end
                    end
                end
            endcase
            for (int j = shadow_count; j > pos; j--) begin
                shadow_entries[j] = shadow_entries[j-1];
            end
            shadow_entries[pos] = v;
            shadow_count++;
            push_beat(1'b0, '0, shadow_count, 1'b0, 1'b1);
        end
    endfunction

    // Predict on every accepted input beat
    always @(posedge i_clk) begin
        if (i_rst_n === 1'b1 && in_ch.valid && in_ch.ready) begin
            apply_list_item(t_op'(in_ch.op), in_ch.value);
        end
    end

    // Compare every accepted result beat with the oldest prediction
    always @(posedge i_clk) begin : result_check
        t_list_beat want;
        if (i_rst_n === 1'b1 && out_ch.valid && out_ch.ready) begin
            if (pending_beats.size() == 0) begin
                note_failure($sformatf(
                    "unexpected beat: hv=%0b elem=%h cnt=%0d drop=%0b last=%0b",
                    out_ch.has_value, out_ch.element, out_ch.entry_count,
                    out_ch.dropped, out_ch.last));
            end else begin
                want = pending_beats.pop_front();
                if (out_ch.has_value !== want.has_value || out_ch.element !== want.element ||
                    out_ch.entry_count !== want.entry_count ||
                    out_ch.dropped !== want.dropped || out_ch.last !== want.last) begin
                    note_failure({
                        $sformatf("beat mismatch: exp hv=%0b elem=%h cnt=%0d drop=%0b last=%0b",
                            want.has_value, want.element, want.entry_count, want.dropped,
                            want.last),
                        $sformatf(", got hv=%0b elem=%h cnt=%0d drop=%0b last=%0b",
                            out_ch.has_value, out_ch.element, out_ch.entry_count,
                            out_ch.dropped, out_ch.last)});
                end
            end
        end
    end

    // Drive ready: random stalls, plus a long hold-off on request
    initial begin : result_receiver
        int hold_left;
        int hold_seen;
        hold_left = 0;
        hold_seen = 0;
        out_ch.ready <= 1'b0;
        forever begin
            @(posedge i_clk);
            if (hold_seen != hold_requests) begin
                hold_seen = hold_requests;
                hold_left = HOLD_CYCLES;
            end
            if (hold_left > 0) begin
                hold_left--;
                out_ch.ready <= 1'b0;
            end else begin
                out_ch.ready <= ($urandom_range(99) >= receiver_stall_pct);
            end
        end
    end

    // Run-time guard
    initial begin : watchdog
        cycle_count = 0;
        while (cycle_count < CYCLE_LIMIT) begin
            @(posedge i_clk);
            cycle_count++;
        end
        $display("testbench NOT OK");
        $finish;
    end

    // Offer one item, idling first at random, and hold it until accepted
    task automatic send_item(t_op op, logic [VALUE_W-1:0] v);
        while ($urandom_range(99) < sender_idle_pct) begin
            in_ch.valid <= 1'b0;
            in_ch.op    <= OP_W'($urandom);
            in_ch.value <= $urandom;
            @(posedge i_clk);
        end
        in_ch.valid <= 1'b1;
        in_ch.op    <= op;
        in_ch.value <= v;
        @(posedge i_clk);
        while (!in_ch.ready) begin
            @(posedge i_clk);
        end
    endtask

    task automatic set_pacing(int idle_pct, int stall_pct);
        sender_idle_pct    = idle_pct;
        receiver_stall_pct = stall_pct;
    endtask

    // Values biased toward extremes and ties with stored entries
    function automatic logic [VALUE_W-1:0] pick_value();
        case ($urandom_range(9))
            0: return MOST_NEGATIVE;
            1: return MOST_POSITIVE;
            2: return '0;
            3: return '1;
            4, 5: begin
                if (shadow_count > 0) begin
                    return shadow_entries[$urandom_range(shadow_count - 1)];
                end
                return $urandom;
            end
            default: return $urandom;
        endcase
    endfunction

    function automatic t_op pick_op();
        int r;
        r = $urandom_range(99);
        if (r < 35) begin
            return OP_SORTED;
        end else if (r < 50) begin
            return OP_FRONT;
        end else if (r < 65) begin
            return OP_BACK;
        end
        return OP_READ;
    endfunction

    task automatic test_empty_read();
        set_pacing(0, 0);
        send_item(OP_READ, 32'h1234_5678);
    endtask

    // Empty list, head greater, tie with head, past the tail, middle
    task automatic test_sorted_placement();
        set_pacing(0, 0);
        send_item(OP_SORTED, '0);
        send_item(OP_SORTED, -32'sd5);
        send_item(OP_SORTED, -32'sd5);
        send_item(OP_SORTED, 32'd100);
        send_item(OP_SORTED, 32'd50);
        send_item(OP_READ, '1);
    endtask

    // Front and back inserts break the order; sorted inserts then stop early
    task automatic test_front_back();
        set_pacing(0, 0);
        send_item(OP_FRONT, MOST_POSITIVE);
        send_item(OP_SORTED, MOST_NEGATIVE);
        send_item(OP_SORTED, 32'd1);
        send_item(OP_BACK, MOST_NEGATIVE);
        send_item(OP_SORTED, '1);
        send_item(OP_READ, '0);
    endtask

    task automatic test_random_traffic();
        int phase_idle [4]  = '{0, 51, 0, 28};
        int phase_stall [4] = '{0, 0, 51, 28};
        for (int p = 0; p < 4; p++) begin
            set_pacing(phase_idle[p], phase_stall[p]);
            for (int n = 0; n < PHASE_ITEMS; n++) begin
                send_item(pick_op(), pick_value());
            end
        end
    endtask

    // Fill to the top, then every insert kind must be dropped
    task automatic test_full_list_drops();
        set_pacing(0, 0);
        for (int n = 0; n < LIST_DEPTH; n++) begin
            send_item(OP_BACK, pick_value());
        end
        send_item(OP_SORTED, MOST_NEGATIVE);
        send_item(OP_FRONT, MOST_POSITIVE);
        send_item(OP_BACK, '0);
        send_item(OP_READ, '1);
    endtask

    // Receiver holds off while items keep coming, so the input stalls
    task automatic test_output_hold();
        set_pacing(0, 0);
        hold_requests++;
        for (int n = 0; n < 24; n++) begin
            send_item(pick_op(), pick_value());
        end
        set_pacing(28, 28);
        hold_requests++;
        for (int n = 0; n < 12; n++) begin
            send_item(pick_op(), pick_value());
        end
    endtask

    // Wait for every predicted beat, then a quiet settling gap
    task automatic drain_results();
        int waited;
        waited = 0;
        in_ch.valid <= 1'b0;
        receiver_stall_pct = 0;
        while (pending_beats.size() != 0 && waited < DRAIN_LIMIT) begin
            @(posedge i_clk);
            waited++;
        end
        repeat (SETTLE_GAP) @(posedge i_clk);
        if (pending_beats.size() != 0) begin
            note_failure($sformatf("%0d predicted beats never arrived", pending_beats.size()));
        end
    endtask

    initial begin
        fail_count         = 0;
        shadow_count       = 0;
        hold_requests      = 0;
        sender_idle_pct    = 0;
        receiver_stall_pct = 0;
        i_rst_n     <= 1'b0;
        in_ch.valid <= 1'b0;
        in_ch.op    <= OP_SORTED;
        in_ch.value <= '0;
        repeat (RESET_CYCLES) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_empty_read();
        test_sorted_placement();
        test_front_back();
        test_random_traffic();
        test_full_list_drops();
        test_output_hold();
        drain_results();

        if (fail_count == 0) begin
            $display("testbench OK");
        end else begin
            $display("testbench NOT OK");
        end
        $finish;
    end

endmodule
